>>> sv/vrsd_pkg.sv
package vrsd_pkg;

    localparam int DEF_MAX_DIM = 256;

    localparam int REQ_W      = 2;
    localparam int WORD_W     = 32;
    localparam int SIZE_W     = 9;
    localparam int OFFS_W     = 16;
    localparam int COORD_W    = 17;
    localparam int RUN_LEFT_W = 17;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [WORD_W-1:0] FLAG_RUN   = WORD_W'(2);
    localparam logic [WORD_W-1:0] FLAG_SLICE = WORD_W'(6);
    localparam logic [CHAN_W-1:0] ALPHA_FULL = CHAN_W'(255);

    typedef enum logic [REQ_W-1:0] {
        REQ_DATA  = 2'd0,
        REQ_DRAIN = 2'd1,
        REQ_NEW   = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 3'd0,
        CFG_HAND     = 3'd1,
        CFG_SIZE_X   = 3'd2,
        CFG_SIZE_Y   = 3'd3,
        CFG_SIZE_Z   = 3'd4,
        CFG_OFFSET_X = 3'd5,
        CFG_OFFSET_Y = 3'd6,
        CFG_OFFSET_Z = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_DRAIN = 2'd1,
        OP_NEW   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] word;
        logic              is_slice;
        logic              is_run;
    } item_t;

    typedef struct packed {
        logic              run_length_mode;
        logic              right_handed;
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic [OFFS_W-1:0] offset_x;
        logic [OFFS_W-1:0] offset_y;
        logic [OFFS_W-1:0] offset_z;
        logic              resize;
    } cfg_t;

    typedef struct packed {
        logic                  voxel_valid;
        logic [COORD_W-1:0]    out_x;
        logic [COORD_W-1:0]    out_y;
        logic [COORD_W-1:0]    out_z;
        logic [CHAN_W-1:0]     red;
        logic [CHAN_W-1:0]     green;
        logic [CHAN_W-1:0]     blue;
        logic [CHAN_W-1:0]     alpha;
        logic [RUN_LEFT_W-1:0] run_left;
        logic                  matrix_done;
    } res_t;

endpackage

>>> sv/voxel_rle_slice_decoder_core.sv
// Voxel word decoder: takes one request per cycle while in_ready is high (data word, run
// drain or new matrix) and returns exactly one result per request, sustained at one item per
// clock while out_ready is high; the rate is set by the single-cycle state update of the
// execute stage. A two-entry queue sits between the input classifier and the execute stage,
// and the result is held in an output register, after a queue entry. Coordinates wrap to 17
// bits; run_left and matrix_done show the state after the request. A write to size_x or size_y
// sets a registered resize flag, which rebuilds the slice row base unless a request executes.
module voxel_rle_slice_decoder_core #(
    parameter int MAX_DIM = vrsd_pkg::DEF_MAX_DIM
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vrsd_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [vrsd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [vrsd_pkg::REQ_W-1:0]        req_type,
    input  logic [vrsd_pkg::WORD_W-1:0]       word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              voxel_valid,
    output logic [vrsd_pkg::COORD_W-1:0]      out_x,
    output logic [vrsd_pkg::COORD_W-1:0]      out_y,
    output logic [vrsd_pkg::COORD_W-1:0]      out_z,
    output logic [vrsd_pkg::CHAN_W-1:0]       red,
    output logic [vrsd_pkg::CHAN_W-1:0]       green,
    output logic [vrsd_pkg::CHAN_W-1:0]       blue,
    output logic [vrsd_pkg::CHAN_W-1:0]       alpha,
    output logic [vrsd_pkg::RUN_LEFT_W-1:0]   run_left,
    output logic                              matrix_done
);
    import vrsd_pkg::*;

    logic              mode_reg;
    logic              hand_reg;
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [OFFS_W-1:0] offset_x_reg, offset_y_reg, offset_z_reg;
    logic              resize_reg, resize_next;

    cfg_t  cfg;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;
    res_t  res;

    assign resize_next = cfg_we && ((cfg_addr == CFG_SIZE_X) || (cfg_addr == CFG_SIZE_Y));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            hand_reg     <= 1'b1;
            size_x_reg   <= SIZE_W'(1);
            size_y_reg   <= SIZE_W'(1);
            size_z_reg   <= SIZE_W'(1);
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
            resize_reg   <= 1'b0;
        end
        else
        begin
            resize_reg <= resize_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_MODE:     mode_reg     <= cfg_wdata[0];
                    CFG_HAND:     hand_reg     <= cfg_wdata[0];
                    CFG_SIZE_X:   size_x_reg   <= cfg_wdata[SIZE_W-1:0];
                    CFG_SIZE_Y:   size_y_reg   <= cfg_wdata[SIZE_W-1:0];
                    CFG_SIZE_Z:   size_z_reg   <= cfg_wdata[SIZE_W-1:0];
                    CFG_OFFSET_X: offset_x_reg <= cfg_wdata[OFFS_W-1:0];
                    CFG_OFFSET_Y: offset_y_reg <= cfg_wdata[OFFS_W-1:0];
                    CFG_OFFSET_Z: offset_z_reg <= cfg_wdata[OFFS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.run_length_mode = mode_reg;
        cfg.right_handed    = hand_reg;
        cfg.size_x          = size_x_reg;
        cfg.size_y          = size_y_reg;
        cfg.size_z          = size_z_reg;
        cfg.offset_x        = offset_x_reg;
        cfg.offset_y        = offset_y_reg;
        cfg.offset_z        = offset_z_reg;
        cfg.resize          = resize_reg;
    end

    vrsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .word     (word),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    vrsd_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign voxel_valid = res.voxel_valid;
    assign out_x       = res.out_x;
    assign out_y       = res.out_y;
    assign out_z       = res.out_z;
    assign red         = res.red;
    assign green       = res.green;
    assign blue        = res.blue;
    assign alpha       = res.alpha;
    assign run_left    = res.run_left;
    assign matrix_done = res.matrix_done;

endmodule

>>> sv/vrsd_front.sv
module vrsd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [vrsd_pkg::REQ_W-1:0]   req_type,
    input  logic [vrsd_pkg::WORD_W-1:0]  word,
    output logic                         q_valid,
    output vrsd_pkg::item_t              q_item,
    input  logic                         q_pop
);
    import vrsd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    item_t             item_in;
    logic              push;

    always_comb
    begin
        item_in.word     = word;
        item_in.is_slice = (word == FLAG_SLICE);
        item_in.is_run   = (word == FLAG_RUN);
        case (req_type)
            REQ_DATA:  item_in.op = OP_DATA;
            REQ_DRAIN: item_in.op = OP_DRAIN;
            REQ_NEW:   item_in.op = OP_NEW;
            default:   item_in.op = OP_NONE;
        endcase
    end

    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

>>> sv/vrsd_back.sv
module vrsd_back #(
    parameter int MAX_DIM = vrsd_pkg::DEF_MAX_DIM
) (
    input  logic             clk,
    input  logic             rst_n,
    input  vrsd_pkg::cfg_t   cfg,
    input  logic             q_valid,
    input  vrsd_pkg::item_t  q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output vrsd_pkg::res_t   res
);
    import vrsd_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CAP_W = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int ROW_W = CAP_W + 1;

    logic [DIM_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [DIM_W-1:0]  slice_reg, slice_next;
    logic [CAP_W-1:0]  rowbase_reg, rowbase_next;
    logic [CAP_W-1:0]  total_reg, total_next;
    logic [CAP_W-1:0]  run_reg, run_next;
    logic [WORD_W-1:0] color_reg, color_next;
    logic              await_count_reg, await_count_next;
    logic              await_color_reg, await_color_next;
    logic              done_reg, done_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg, res_next;

    logic [DIM_W-1:0]   sx_eff, sy_eff, sz_eff;
    logic               exec;
    logic [DIM_W-1:0]   col_inc, adv_col, slice_inc;
    logic               wrap_col;
    logic [ROW_W-1:0]   adv_row;
    logic [CAP_W-1:0]   adv_rowbase;
    logic               raw_row_wrap;
    logic [CAP_W:0]     idx;
    logic [CAP_W-1:0]   cap;
    logic [CAP_W-1:0]   run_load;
    logic               emit;
    logic [WORD_W-1:0]  emit_color;
    logic [COORD_W-1:0] vx, vy, vz;

    always_comb
    begin
        if (cfg.size_x == '0)
            sx_eff = DIM_W'(1);
        else if (32'(cfg.size_x) > MAX_DIM)
            sx_eff = DIM_W'(MAX_DIM);
        else
            sx_eff = DIM_W'(cfg.size_x);
        if (cfg.size_y == '0)
            sy_eff = DIM_W'(1);
        else if (32'(cfg.size_y) > MAX_DIM)
            sy_eff = DIM_W'(MAX_DIM);
        else
            sy_eff = DIM_W'(cfg.size_y);
        if (cfg.size_z == '0)
            sz_eff = DIM_W'(1);
        else if (32'(cfg.size_z) > MAX_DIM)
            sz_eff = DIM_W'(MAX_DIM);
        else
            sz_eff = DIM_W'(cfg.size_z);
    end

    assign total_next = CAP_W'(sx_eff) * CAP_W'(sy_eff);

    assign exec  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = exec;

    // one step along x, wrapping into y
    assign col_inc     = col_reg + 1'b1;
    assign wrap_col    = (col_inc >= sx_eff);
    assign adv_col     = wrap_col ? '0 : col_inc;
    assign adv_row     = wrap_col ? row_reg + 1'b1 : row_reg;
    assign adv_rowbase = wrap_col ? rowbase_reg + CAP_W'(sx_eff) : rowbase_reg;
    assign raw_row_wrap = (adv_row >= ROW_W'(sy_eff));
    assign slice_inc   = slice_reg + 1'b1;

    // voxels left in the current slice
    assign idx = (CAP_W+1)'(rowbase_reg) + (CAP_W+1)'(col_reg);
    always_comb
    begin
        if ((row_reg < ROW_W'(sy_eff)) && (idx < (CAP_W+1)'(total_reg)))
            cap = total_reg - idx[CAP_W-1:0];
        else
            cap = '0;
        run_load = (q_item.word < 32'(cap)) ? CAP_W'(q_item.word) : cap;
    end

    assign emit_color = (q_item.op == OP_DRAIN) ? color_reg : q_item.word;
    assign vx = COORD_W'($signed(cfg.offset_x)) + COORD_W'(col_reg);
    assign vy = COORD_W'($signed(cfg.offset_y)) + COORD_W'(row_reg);
    assign vz = COORD_W'($signed(cfg.offset_z)) + COORD_W'(slice_reg);

    always_comb
    begin
        col_next         = col_reg;
        row_next         = row_reg;
        slice_next       = slice_reg;
        rowbase_next     = rowbase_reg;
        run_next         = run_reg;
        color_next       = color_reg;
        await_count_next = await_count_reg;
        await_color_next = await_color_reg;
        done_next        = done_reg;
        emit             = 1'b0;
        if (exec)
        begin
            case (q_item.op)
                OP_NEW:
                begin
                    col_next         = '0;
                    row_next         = '0;
                    slice_next       = '0;
                    rowbase_next     = '0;
                    run_next         = '0;
                    color_next       = '0;
                    await_count_next = 1'b0;
                    await_color_next = 1'b0;
                    done_next        = 1'b0;
                end
                OP_DRAIN:
                begin
                    if (!done_reg && (run_reg != '0))
                    begin
                        emit         = 1'b1;
                        col_next     = adv_col;
                        row_next     = adv_row;
                        rowbase_next = adv_rowbase;
                        run_next     = run_reg - 1'b1;
                    end
                end
                OP_DATA:
                begin
                    if (!done_reg && (run_reg == '0))
                    begin
                        if (!cfg.run_length_mode)
                        begin
                            emit     = (q_item.word[31:24] != '0);
                            col_next = adv_col;
                            if (raw_row_wrap)
                            begin
                                row_next     = '0;
                                rowbase_next = '0;
                                slice_next   = slice_inc;
                                done_next    = (slice_inc >= sz_eff);
                            end
                            else
                            begin
                                row_next     = adv_row;
                                rowbase_next = adv_rowbase;
                                done_next    = (slice_reg >= sz_eff);
                            end
                        end
                        else if (await_count_reg)
                        begin
                            run_next         = run_load;
                            await_count_next = 1'b0;
                            await_color_next = 1'b1;
                        end
                        else if (await_color_reg)
                        begin
                            color_next       = q_item.word;
                            await_color_next = 1'b0;
                        end
                        else if (q_item.is_slice)
                        begin
                            col_next     = '0;
                            row_next     = '0;
                            rowbase_next = '0;
                            slice_next   = slice_inc;
                            done_next    = (slice_inc >= sz_eff);
                        end
                        else if (q_item.is_run)
                        begin
                            await_count_next = 1'b1;
                        end
                        else if (cap != '0)
                        begin
                            emit         = 1'b1;
                            col_next     = adv_col;
                            row_next     = adv_row;
                            rowbase_next = adv_rowbase;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cfg.resize)
        begin
            // width or height changed: rebuild row start; rows past MAX_DIM never fit
            if (row_reg < ROW_W'(MAX_DIM))
                rowbase_next = CAP_W'(row_reg[DIM_W-1:0]) * CAP_W'(sx_eff);
            else
                rowbase_next = '0;
        end
    end

    always_comb
    begin
        res_next = '0;
        if (emit)
        begin
            res_next.voxel_valid = 1'b1;
            res_next.out_x       = vx;
            res_next.out_y       = cfg.right_handed ? vz : COORD_W'(0) - vz;
            res_next.out_z       = vy;
            res_next.red         = emit_color[7:0];
            res_next.green       = emit_color[15:8];
            res_next.blue        = emit_color[23:16];
            res_next.alpha       = (emit_color[31:24] != '0) ? ALPHA_FULL : '0;
        end
        res_next.run_left    = RUN_LEFT_W'(run_next);
        res_next.matrix_done = done_next;
    end

    always_comb
    begin
        if (exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            slice_reg       <= '0;
            rowbase_reg     <= '0;
            total_reg       <= CAP_W'(1);
            run_reg         <= '0;
            color_reg       <= '0;
            await_count_reg <= 1'b0;
            await_color_reg <= 1'b0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            slice_reg       <= slice_next;
            rowbase_reg     <= rowbase_next;
            total_reg       <= total_next;
            run_reg         <= run_next;
            color_reg       <= color_next;
            await_count_reg <= await_count_next;
            await_color_reg <= await_color_next;
            done_reg        <= done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    a_new_clears: assert property (@(posedge clk) disable iff (!rst_n)
        exec && (q_item.op == OP_NEW) |=>
            !done_reg && (run_reg == '0) && !await_count_reg && !await_color_reg)
        else $error("new matrix did not clear decoder state");

    a_await_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(await_count_reg && await_color_reg))
        else $error("count and colour awaited together");

    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.voxel_valid |->
            (res_reg.out_x == '0) && (res_reg.out_y == '0) && (res_reg.alpha == '0))
        else $error("non-voxel result carries voxel fields");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(exec && (q_item.op == OP_DATA)))
        else $error("matrix done raised without a data word");

endmodule
